// ===== rtl/linked_list_table_manager_defines.svh =====
// Assertion macros shared by the linked list table manager RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef LINKED_LIST_TABLE_MANAGER_DEFINES_SVH
`define LINKED_LIST_TABLE_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define LLTM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LLTM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define LLTM_ASSERT(name, clk, rst, prop, msg)
`define LLTM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/lltm_pkg.sv =====
// Types, constants and link reset functions of the linked list table manager.
// No dependencies; imported by every module of the block but lltm_ram.
`default_nettype none

package lltm_pkg;

   localparam int CAPACITY = 128;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LINK_W   = IDX_W + 1;
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   localparam int REQ_TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((IDX_W + 1 + DATA_W + LEN_W + 7) / 8) * 8;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [LINK_W-1:0] link_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [LEN_W-1:0]  len_type;

   // Null link: one past the last slot.
   localparam link_type NIL = LINK_W'(CAPACITY);

   typedef enum logic [1:0] {
      FUNC_INSERT    = 2'd0,
      FUNC_REMOVE    = 2'd1,
      FUNC_GET_NEXT  = 2'd2,
      FUNC_GET_FIRST = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_DATA = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_LINK1,
      ST_LINK2,
      ST_LINK3,
      ST_FETCH,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_START,
      STEP_LINK1,
      STEP_LINK2,
      STEP_LINK3,
      STEP_FETCH
   } step_type;

   typedef struct packed {
      logic     load;
      step_type step;
      logic     emit;
   } ctrl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     no_data;
      logic     head_null;
      logic     next_null;
   } dp_status_type;

   // Free list threading after reset: slot i points forward to i+1.
   function automatic link_type next_reset_link(input idx_type idx);
      link_type r;
      if (idx == IDX_W'(CAPACITY - 1)) r = NIL;
      else r = LINK_W'(idx) + LINK_W'(1);
      return r;
   endfunction

   // Free list threading after reset: slot i points back to i-1.
   function automatic link_type prev_reset_link(input idx_type idx);
      link_type r;
      if (idx == '0) r = NIL;
      else r = LINK_W'(idx) - LINK_W'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lltm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lltm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lltm_ctrl.sv =====
// Sequencer of the linked list table manager: steps each request through
// its memory phases and owns the handshakes. Depends on lltm_pkg.
`default_nettype none

module lltm_ctrl import lltm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_START;
         end
         ST_START: begin
            case (status.func)
               FUNC_INSERT:    state_in = status.full ? ST_DONE : ST_LINK1;
               FUNC_GET_FIRST: state_in = status.head_null ? ST_DONE : ST_FETCH;
               default:        state_in = status.no_data ? ST_DONE : ST_LINK1;
            endcase
         end
         ST_LINK1: begin
            if (status.func == FUNC_GET_NEXT) begin
               state_in = status.next_null ? ST_DONE : ST_FETCH;
            end else begin
               state_in = ST_LINK2;
            end
         end
         ST_LINK2: begin
            state_in = (status.func == FUNC_REMOVE) ? ST_LINK3 : ST_DONE;
         end
         ST_LINK3: state_in = ST_DONE;
         ST_FETCH: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '{load: 1'b0, step: STEP_NONE, emit: 1'b0};
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_START: cmd.step = STEP_START;
         ST_LINK1: cmd.step = STEP_LINK1;
         ST_LINK2: cmd.step = STEP_LINK2;
         ST_LINK3: cmd.step = STEP_LINK3;
         ST_FETCH: cmd.step = STEP_FETCH;
         ST_DONE:  cmd.emit = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/lltm_dpath.sv =====
// Datapath of the linked list table manager: list pointers, link and data
// memories, result registers. Depends on lltm_pkg, lltm_ram and the defines.
`default_nettype none
`include "linked_list_table_manager_defines.svh"

module lltm_dpath import lltm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status,
   input  wire func_type     in_func,
   input  wire data_type     in_item,
   input  wire idx_type      in_slot,
   output status_type        out_status,
   output idx_type           out_index,
   output logic              out_valid,
   output data_type          out_data,
   output len_type           out_length
);

   // Latched request.
   func_type func_ff, func_in;
   data_type item_ff, item_in;
   idx_type  slot_ff, slot_in;

   // List ends and occupancy.
   link_type data_head_ff, data_head_in;
   link_type data_tail_ff, data_tail_in;
   link_type free_head_ff, free_head_in;
   link_type free_tail_ff, free_tail_in;
   len_type  length_ff, length_in;
   logic [CAPACITY-1:0] occupied_ff, occupied_in;

   // Per-entry written marks; an unwritten link reads as its reset value.
   logic [CAPACITY-1:0] next_written_ff, next_written_in;
   logic [CAPACITY-1:0] prev_written_ff, prev_written_in;
   logic    next_init_ff, next_init_in;
   logic    prev_init_ff, prev_init_in;
   idx_type next_raddr_ff, next_raddr_in;
   idx_type prev_raddr_ff, prev_raddr_in;

   // Result under construction and output register.
   status_type res_status_ff, res_status_in;
   idx_type    res_index_ff, res_index_in;
   logic       res_valid_ff, res_valid_in;
   data_type   res_data_ff, res_data_in;
   status_type rsp_status_ff, rsp_status_in;
   idx_type    rsp_index_ff, rsp_index_in;
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_data_ff, rsp_data_in;
   len_type    rsp_length_ff, rsp_length_in;

   // Memory ports.
   logic     next_we, next_re, prev_we, prev_re, data_we, data_re;
   idx_type  next_waddr, next_raddr, prev_waddr, prev_raddr, data_waddr, data_raddr;
   link_type next_wdata, prev_wdata, next_q, prev_q, next_rd, prev_rd;
   data_type data_wdata, data_q;

   idx_type fh_idx, head_idx, tail_idx;
   logic    full, no_data, head_null;

   lltm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (next_re),
      .rd_addr (next_raddr),
      .rd_data (next_q)
   );

   lltm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (prev_re),
      .rd_addr (prev_raddr),
      .rd_data (prev_q)
   );

   lltm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_en   (data_re),
      .rd_addr (data_raddr),
      .rd_data (data_q)
   );

   assign next_rd = next_init_ff ? next_reset_link(next_raddr_ff) : next_q;
   assign prev_rd = prev_init_ff ? prev_reset_link(prev_raddr_ff) : prev_q;

   assign fh_idx    = free_head_ff[IDX_W-1:0];
   assign head_idx  = data_head_ff[IDX_W-1:0];
   assign tail_idx  = data_tail_ff[IDX_W-1:0];
   assign full      = (free_head_ff == NIL);
   assign head_null = (data_head_ff == NIL);
   assign no_data   = !occupied_ff[slot_ff];

   assign status = '{func: func_ff, full: full, no_data: no_data,
                     head_null: head_null, next_null: (next_rd == NIL)};

   always_comb begin
      func_in         = func_ff;
      item_in         = item_ff;
      slot_in         = slot_ff;
      data_head_in    = data_head_ff;
      data_tail_in    = data_tail_ff;
      free_head_in    = free_head_ff;
      free_tail_in    = free_tail_ff;
      length_in       = length_ff;
      occupied_in     = occupied_ff;
      next_written_in = next_written_ff;
      prev_written_in = prev_written_ff;
      next_init_in    = next_init_ff;
      prev_init_in    = prev_init_ff;
      next_raddr_in   = next_raddr_ff;
      prev_raddr_in   = prev_raddr_ff;
      res_status_in   = res_status_ff;
      res_index_in    = res_index_ff;
      res_valid_in    = res_valid_ff;
      res_data_in     = res_data_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_length_in   = rsp_length_ff;

      next_we = 1'b0; next_waddr = '0; next_wdata = '0;
      next_re = 1'b0; next_raddr = '0;
      prev_we = 1'b0; prev_waddr = '0; prev_wdata = '0;
      prev_re = 1'b0; prev_raddr = '0;
      data_we = 1'b0; data_waddr = '0; data_wdata = '0;
      data_re = 1'b0; data_raddr = '0;

      if (cmd.load) begin
         func_in = in_func;
         item_in = in_item;
         slot_in = in_slot;
      end

      unique case (cmd.step)
         STEP_START: begin
            res_status_in = STAT_OK;
            res_valid_in  = 1'b0;
            res_index_in  = '0;
            res_data_in   = '0;
            case (func_ff) inside
               FUNC_INSERT: begin
                  if (full) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     data_we    = 1'b1;
                     data_waddr = fh_idx;
                     data_wdata = item_ff;
                     next_re    = 1'b1;
                     next_raddr = fh_idx;
                     occupied_in[fh_idx] = 1'b1;
                     res_valid_in = 1'b1;
                     res_index_in = fh_idx;
                     res_data_in  = item_ff;
                  end
               end
               FUNC_REMOVE, FUNC_GET_NEXT: begin
                  if (no_data) begin
                     res_status_in = STAT_NO_DATA;
                  end else begin
                     next_re    = 1'b1;
                     next_raddr = slot_ff;
                     prev_re    = 1'b1;
                     prev_raddr = slot_ff;
                  end
               end
               default: begin
                  if (!head_null) begin
                     data_re      = 1'b1;
                     data_raddr   = head_idx;
                     res_valid_in = 1'b1;
                     res_index_in = head_idx;
                  end
               end
            endcase
         end
         STEP_LINK1: begin
            case (func_ff)
               FUNC_INSERT: begin
                  // Pop the free head (its next link is the new free head) and link the old data tail to the new slot.
                  if (data_tail_ff != NIL) begin
                     next_we    = 1'b1;
                     next_waddr = tail_idx;
                     next_wdata = LINK_W'(res_index_ff);
                  end
                  if (next_rd != NIL) begin
                     prev_we    = 1'b1;
                     prev_waddr = next_rd[IDX_W-1:0];
                     prev_wdata = NIL;
                  end else begin
                     free_tail_in = NIL;
                  end
                  free_head_in = next_rd;
               end
               FUNC_GET_NEXT: begin
                  if (next_rd != NIL) begin
                     data_re      = 1'b1;
                     data_raddr   = next_rd[IDX_W-1:0];
                     res_valid_in = 1'b1;
                     res_index_in = next_rd[IDX_W-1:0];
                  end
               end
               FUNC_REMOVE: begin
                  // Unlink from the data list.
                  if (prev_rd != NIL) begin
                     next_we    = 1'b1;
                     next_waddr = prev_rd[IDX_W-1:0];
                     next_wdata = next_rd;
                  end else begin
                     data_head_in = next_rd;
                  end
                  if (next_rd != NIL) begin
                     prev_we    = 1'b1;
                     prev_waddr = next_rd[IDX_W-1:0];
                     prev_wdata = prev_rd;
                  end else begin
                     data_tail_in = prev_rd;
                  end
                  occupied_in[slot_ff] = 1'b0;
                  if (length_ff != '0) length_in = length_ff - LEN_W'(1);
               end
               default: ;
            endcase
         end
         STEP_LINK2: begin
            if (func_ff == FUNC_INSERT) begin
               // Append the new slot at the data tail.
               next_we    = 1'b1;
               next_waddr = res_index_ff;
               next_wdata = NIL;
               prev_we    = 1'b1;
               prev_waddr = res_index_ff;
               prev_wdata = data_tail_ff;
               data_tail_in = LINK_W'(res_index_ff);
               if (head_null) data_head_in = LINK_W'(res_index_ff);
               length_in = length_ff + LEN_W'(1);
            end else begin
               next_we    = 1'b1;
               next_waddr = slot_ff;
               next_wdata = NIL;
               prev_we    = 1'b1;
               prev_waddr = slot_ff;
               prev_wdata = free_tail_ff;
            end
         end
         STEP_LINK3: begin
            // Append the freed slot at the free tail.
            if (free_tail_ff != NIL) begin
               next_we    = 1'b1;
               next_waddr = free_tail_ff[IDX_W-1:0];
               next_wdata = LINK_W'(slot_ff);
            end else begin
               free_head_in = LINK_W'(slot_ff);
            end
            free_tail_in = LINK_W'(slot_ff);
         end
         STEP_FETCH: res_data_in = data_q;
         default: ;
      endcase

      if (next_we) next_written_in[next_waddr] = 1'b1;
      if (prev_we) prev_written_in[prev_waddr] = 1'b1;
      if (next_re) begin
         next_init_in  = !next_written_ff[next_raddr];
         next_raddr_in = next_raddr;
      end
      if (prev_re) begin
         prev_init_in  = !prev_written_ff[prev_raddr];
         prev_raddr_in = prev_raddr;
      end

      if (cmd.emit) begin
         rsp_status_in = res_status_ff;
         rsp_index_in  = res_index_ff;
         rsp_valid_in  = res_valid_ff;
         rsp_data_in   = res_data_ff;
         rsp_length_in = length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_head_ff    <= NIL;
         data_tail_ff    <= NIL;
         free_head_ff    <= '0;
         free_tail_ff    <= LINK_W'(CAPACITY - 1);
         length_ff       <= '0;
         occupied_ff     <= '0;
         next_written_ff <= '0;
         prev_written_ff <= '0;
         next_init_ff    <= 1'b1;
         prev_init_ff    <= 1'b1;
      end else begin
         data_head_ff    <= data_head_in;
         data_tail_ff    <= data_tail_in;
         free_head_ff    <= free_head_in;
         free_tail_ff    <= free_tail_in;
         length_ff       <= length_in;
         occupied_ff     <= occupied_in;
         next_written_ff <= next_written_in;
         prev_written_ff <= prev_written_in;
         next_init_ff    <= next_init_in;
         prev_init_ff    <= prev_init_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      item_ff       <= item_in;
      slot_ff       <= slot_in;
      next_raddr_ff <= next_raddr_in;
      prev_raddr_ff <= prev_raddr_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_valid_ff  <= res_valid_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign out_status = rsp_status_ff;
   assign out_index  = rsp_index_ff;
   assign out_valid  = rsp_valid_ff;
   assign out_data   = rsp_data_ff;
   assign out_length = rsp_length_ff;

   `LLTM_ASSERT(a_len_max, clock, reset, length_ff <= LEN_W'(CAPACITY), "list length beyond capacity")
   `LLTM_ASSERT(a_data_ends, clock, reset, (data_head_ff == NIL) == (data_tail_ff == NIL), "data list head and tail disagree on empty")
   `LLTM_ASSERT(a_free_ends, clock, reset, (free_head_ff == NIL) == (free_tail_ff == NIL), "free list head and tail disagree on empty")
   `LLTM_ASSERT_IMPLY(a_empty_len, clock, reset, data_head_ff == NIL, length_ff == '0, "empty data list with nonzero length")

endmodule

`default_nettype wire

// ===== rtl/linked_list_table_manager.sv =====
// Top level of the linked list table manager: stream ports, sequencer and
// datapath. Depends on lltm_pkg, lltm_ctrl and lltm_dpath.
`default_nettype none

// A table of CAPACITY slots threaded into two doubly linked lists, one of
// occupied slots holding data and one of free slots. Each request carries an
// operation in req_tuser: insert takes the free-list head, stores the data
// word there and appends the slot at the data tail (status full when no slot
// is free); remove unlinks an occupied slot and appends it to the free tail;
// get-first returns the data head; get-next returns the successor of an
// occupied slot. Remove and get-next on an empty slot answer "no data" and
// change nothing. Every response carries the list length after the request,
// and index and data are zero whenever the valid flag is low. One request is
// in flight at a time, and the next one is taken while the last response
// still waits in the output register. Each request runs a start step, then
// the link steps it needs and a fetch step when it returns stored data;
// each link memory has a single write port, so remove rewrites the
// predecessor, the slot itself and the free tail in turn, and every
// memory read is registered. Link memories come up in their free-list
// order without a clearing pass; reset is immediate.
module linked_list_table_manager import lltm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // item_data [31:0], slot_index [38:32], zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func [1:0]
   input  wire logic [1:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // result_index [6:0], result_valid [7], result_data [39:8], list_length [47:40]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // status [1:0]
   output logic [1:0]                  rsp_tuser
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   status_type    out_status;
   idx_type       out_index;
   logic          out_valid;
   data_type      out_data;
   len_type       out_length;

   lltm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lltm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_func    (func_type'(req_tuser)),
      .in_item    (req_tdata[DATA_W-1:0]),
      .in_slot    (req_tdata[DATA_W +: IDX_W]),
      .out_status (out_status),
      .out_index  (out_index),
      .out_valid  (out_valid),
      .out_data   (out_data),
      .out_length (out_length)
   );

   // Pack the response fields from the lowest bit up.
   assign rsp_tdata = RSP_TDATA_W'({out_length, out_data, out_valid, out_index});
   assign rsp_tuser = out_status;

endmodule

`default_nettype wire
